### hw/rtl/u8ptc_pkg.sv
// ----------------------------------------------------------------------------
// u8ptc_pkg
// Shared types, constants and helper functions for the printable UTF-8
// text checker.
// ----------------------------------------------------------------------------
package u8ptc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;  // code point accumulator width
  localparam int unsigned LenW  = 3;   // sequence length width
  localparam int unsigned ContW = 2;   // continuation count width

  localparam logic [LenW-1:0] SeqLen2 = LenW'(2);
  localparam logic [LenW-1:0] SeqLen3 = LenW'(3);
  localparam logic [LenW-1:0] SeqLen4 = LenW'(4);

  localparam logic [CpW-1:0] CpMin2     = CpW'(21'h00080);
  localparam logic [CpW-1:0] CpMin3     = CpW'(21'h00800);
  localparam logic [CpW-1:0] CpMin4     = CpW'(21'h10000);
  localparam logic [CpW-1:0] CpMax      = CpW'(21'h10FFFF);
  localparam logic [CpW-1:0] SurrogateLo = CpW'(21'h0D800);
  localparam logic [CpW-1:0] SurrogateHi = CpW'(21'h0DFFF);

  // Result handed from the checker core to the output register
  typedef struct packed {
    logic vld;
    logic verdict;
  } u8ptc_res_t;

  // Tab, newline, carriage return and visible ASCII
  function automatic logic is_printable(input logic [ByteW-1:0] b);
    return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
           ((b >= 8'h20) && (b <= 8'h7E));
  endfunction

  // Overlong form, out of range or surrogate
  function automatic logic seq_bad(input logic [LenW-1:0] len,
                                   input logic [CpW-1:0]  cp);
    logic bad;
    bad = 1'b0;
    if ((len == SeqLen2) && (cp < CpMin2)) bad = 1'b1;
    if ((len == SeqLen3) && (cp < CpMin3)) bad = 1'b1;
    if ((len == SeqLen4) && (cp < CpMin4)) bad = 1'b1;
    if (cp > CpMax) bad = 1'b1;
    if ((cp >= SurrogateLo) && (cp <= SurrogateHi)) bad = 1'b1;
    return bad;
  endfunction

endpackage

### hw/rtl/utf8_printable_text_check.sv
// Path: the last byte passes from the input register through the decoder
//   logic, and its verdict lands in the result register that drives out_valid_o.
// Throughput: one byte per cycle; the input stalls only while a last byte
//   waits in the input register behind a verdict that is still held.
// Reset: rst_ni clears the decoder state and both stage valids at once.
// ----------------------------------------------------------------------------
// utf8_printable_text_check
// Checks a byte stream message for printable UTF-8 text and reports one
// verdict per message.
// ----------------------------------------------------------------------------
module utf8_printable_text_check
  import u8ptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             verdict_o
);

  logic             s1_vld_q, s1_vld_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic             s1_adv;
  logic             take;
  logic             out_vld_q, out_vld_d;
  logic             out_verdict_q;
  logic             core_busy;
  u8ptc_res_t       res;

  // Advance unless a last byte waits on a held result
  assign s1_adv     = !(s1_last_q && out_vld_q && out_stall_i);
  assign take       = s1_vld_q && s1_adv;
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign s1_vld_d   = in_stall_o ? s1_vld_q : in_valid_i;

  u8ptc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .res_o  (res),
    .busy_o (core_busy)
  );

  // Load a new verdict or drop the delivered one
  assign out_vld_d = res.vld | (out_vld_q & out_stall_i);

  // Hold stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (res.vld) begin
      out_verdict_q <= res.verdict;
    end
  end

  assign out_valid_o = out_vld_q;
  assign verdict_o   = out_verdict_q;

`ifndef SYNTHESIS
  // A verdict is only produced when the result register can take it
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.vld |-> (!out_vld_q || !out_stall_i))
    else $error("verdict produced while result register is held");

  // Decoder state is clear after a verdict
  a_clear_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.vld |=> !core_busy)
    else $error("decoder state not cleared after verdict");

  // Input stalls only while a byte sits in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && s1_last_q && out_vld_q))
    else $error("input stalled without a blocked last byte");
`endif

endmodule

### hw/rtl/u8ptc_core.sv
// ----------------------------------------------------------------------------
// u8ptc_core
// Decoder state and combinational byte step: tracks multi-byte sequences,
// latches the first error and produces the verdict on the last byte.
// ----------------------------------------------------------------------------
module u8ptc_core
  import u8ptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  output u8ptc_res_t       res_o,
  output logic             busy_o
);

  logic [ContW-1:0] cont_q, cont_d;
  logic [LenW-1:0]  len_q,  len_d;
  logic [CpW-1:0]   acc_q,  acc_d;
  logic             err_q,  err_d;
  logic [CpW-1:0]   acc_next;

  // Shift in six payload bits of a continuation byte
  assign acc_next = {acc_q[CpW-7:0], byte_i[5:0]};

  // Step the decoder by one byte
  always_comb begin
    cont_d        = cont_q;
    len_d         = len_q;
    acc_d         = acc_q;
    err_d         = err_q;
    res_o.vld     = 1'b0;
    res_o.verdict = 1'b0;
    if (take_i) begin
      if (!err_q) begin
        if (cont_q == '0) begin
          if (is_printable(byte_i)) begin
            cont_d = cont_q;
          end else if (byte_i inside {[8'hC2:8'hDF]}) begin
            len_d  = SeqLen2;
            acc_d  = CpW'(byte_i[4:0]);
            cont_d = ContW'(1);
          end else if (byte_i inside {[8'hE0:8'hEF]}) begin
            len_d  = SeqLen3;
            acc_d  = CpW'(byte_i[3:0]);
            cont_d = ContW'(2);
          end else if (byte_i inside {[8'hF0:8'hF4]}) begin
            len_d  = SeqLen4;
            acc_d  = CpW'(byte_i[2:0]);
            cont_d = ContW'(3);
          end else begin
            err_d = 1'b1;
          end
        end else if (byte_i[7:6] != 2'b10) begin
          err_d = 1'b1;
        end else begin
          acc_d  = acc_next;
          cont_d = cont_q - ContW'(1);
          if (cont_q == ContW'(1)) begin
            if (seq_bad(len_q, acc_next)) err_d = 1'b1;
            len_d = '0;
            acc_d = '0;
          end
        end
      end
      // Report on the last byte and clear for the next message
      if (last_i) begin
        res_o.vld     = 1'b1;
        res_o.verdict = err_d | (cont_d != '0);
        cont_d        = '0;
        len_d         = '0;
        acc_d         = '0;
        err_d         = 1'b0;
      end
    end
  end

  assign busy_o = (cont_q != '0) || err_q;

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q <= '0;
      len_q  <= '0;
      acc_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      cont_q <= cont_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      err_q  <= err_d;
    end
  end

endmodule
